[src/trrc_pkg.sv]
// ----------------------------------------------------------------------------
// trrc_pkg
// Types, constants and helper functions of the thermal ramp-rate cycler.
// ----------------------------------------------------------------------------
package trrc_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int TEMP_W     = 16;
  localparam int POWER_W    = 16;
  localparam int DISP_W     = 8;
  localparam int MS_W       = 16;
  localparam int FTC_W      = 10;
  localparam int TURN_W     = 15;

  localparam logic [16:0] RATE_SCALE = 17'd62500;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_TURN   = 4'd0,
    REG_LOWER_TURN   = 4'd1,
    REG_RATE_LOW     = 4'd2,
    REG_RATE_HIGH    = 4'd3,
    REG_POWER_STEP   = 4'd4,
    REG_FAULT_STEP   = 4'd5,
    REG_TIMEOUT      = 4'd6,
    REG_FAULT_PERIOD = 4'd7
  } cfg_reg_t;

  localparam logic [TURN_W-1:0] RST_UPPER_TURN   = 15'd25600;
  localparam logic [TURN_W-1:0] RST_LOWER_TURN   = 15'd4800;
  localparam logic [15:0]       RST_RATE_LOW     = 16'd800;
  localparam logic [15:0]       RST_RATE_HIGH    = 16'd1200;
  localparam logic [15:0]       RST_POWER_STEP   = 16'd131;
  localparam logic [15:0]       RST_FAULT_STEP   = 16'd655;
  localparam logic [MS_W-1:0]   RST_TIMEOUT      = 16'd5000;
  localparam logic [FTC_W-1:0]  RST_FAULT_PERIOD = 10'd100;

  typedef struct packed {
    logic [TURN_W-1:0]  upper_turn;
    logic [TURN_W-1:0]  lower_turn;
    logic [15:0]        rate_low;
    logic [15:0]        rate_high;
    logic [15:0]        power_step;
    logic [15:0]        fault_step;
    logic [MS_W-1:0]    timeout;
    logic [FTC_W-1:0]   fault_period;
  } cfg_t;

  typedef struct packed {
    logic [POWER_W-1:0]       power;
    logic                     heating;
    logic                     have_ref;
    logic signed [TEMP_W-1:0] last_temp;
    logic [MS_W-1:0]          ms;
    logic                     fault;
    logic [FTC_W-1:0]         ftc;
  } state_t;

  function automatic logic [POWER_W-1:0] pwr_up(input logic [POWER_W-1:0] p,
                                                input logic [15:0] amt);
    logic [POWER_W:0] s;
    s = {1'b0, p} + {1'b0, amt};
    return s[POWER_W] ? {POWER_W{1'b1}} : s[POWER_W-1:0];
  endfunction

  function automatic logic [POWER_W-1:0] pwr_down(input logic [POWER_W-1:0] p,
                                                  input logic [15:0] amt);
    return (amt >= p) ? '0 : p - amt;
  endfunction

  // floor(p*255/65535) == floor(p/257) == (p - (p >> 8)) >> 8
  function automatic logic [DISP_W-1:0] disp_byte(input logic [POWER_W-1:0] p);
    logic [POWER_W-1:0] d;
    d = p - {8'd0, p[15:8]};
    return d[15:8];
  endfunction

endpackage

[src/trrc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// trrc_cfg_regs
// Configuration register file, written by index over the cfg channel.
// ----------------------------------------------------------------------------
module trrc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [trrc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [trrc_pkg::CFG_DATA_W-1:0]  wr_data,
  output trrc_pkg::cfg_t                   cfg
);
  import trrc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_UPPER_TURN:   cfg_nxt.upper_turn   = wr_data[TURN_W-1:0];
        REG_LOWER_TURN:   cfg_nxt.lower_turn   = wr_data[TURN_W-1:0];
        REG_RATE_LOW:     cfg_nxt.rate_low     = wr_data;
        REG_RATE_HIGH:    cfg_nxt.rate_high    = wr_data;
        REG_POWER_STEP:   cfg_nxt.power_step   = wr_data;
        REG_FAULT_STEP:   cfg_nxt.fault_step   = wr_data;
        REG_TIMEOUT:      cfg_nxt.timeout      = wr_data;
        REG_FAULT_PERIOD: cfg_nxt.fault_period = wr_data[FTC_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_turn   <= RST_UPPER_TURN;
      cfg_r.lower_turn   <= RST_LOWER_TURN;
      cfg_r.rate_low     <= RST_RATE_LOW;
      cfg_r.rate_high    <= RST_RATE_HIGH;
      cfg_r.power_step   <= RST_POWER_STEP;
      cfg_r.fault_step   <= RST_FAULT_STEP;
      cfg_r.timeout      <= RST_TIMEOUT;
      cfg_r.fault_period <= RST_FAULT_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/trrc_step.sv]
// ----------------------------------------------------------------------------
// trrc_step
// Next-state logic for one tick or sample: rate compare, power update,
// phase turn, timeout and fault-period power decrement.
// ----------------------------------------------------------------------------
module trrc_step (
  input  trrc_pkg::cfg_t                   cfg,
  input  trrc_pkg::state_t                 st,
  input  logic                             opcode,
  input  logic signed [trrc_pkg::TEMP_W-1:0] temperature,
  output trrc_pkg::state_t                 st_nxt,
  output logic                             emit
);
  import trrc_pkg::*;

  logic [MS_W-1:0]   ms_inc;
  logic [FTC_W-1:0]  ftc_inc;
  logic signed [16:0] diff;
  logic signed [33:0] lhs;
  logic [31:0]        lo_u, hi_u;
  logic signed [33:0] lo_s, hi_s;
  logic signed [TEMP_W-1:0] upper_s, lower_s;

  assign ms_inc  = (st.ms == {MS_W{1'b1}}) ? st.ms : st.ms + 1'b1;
  assign ftc_inc = st.ftc + 1'b1;

  assign diff = {temperature[TEMP_W-1], temperature} - {st.last_temp[TEMP_W-1], st.last_temp};
  assign lhs  = 34'(diff) * $signed({17'd0, RATE_SCALE});
  assign lo_u = 32'(cfg.rate_low) * 32'(st.ms);
  assign hi_u = 32'(cfg.rate_high) * 32'(st.ms);
  assign lo_s = $signed({2'b00, lo_u});
  assign hi_s = $signed({2'b00, hi_u});

  assign upper_s = $signed({1'b0, cfg.upper_turn});
  assign lower_s = $signed({1'b0, cfg.lower_turn});

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    if (opcode == OP_TICK) begin
      st_nxt.ms = ms_inc;
      if (!st.fault) begin
        if (ms_inc > cfg.timeout) begin
          st_nxt.fault = 1'b1;
          st_nxt.ftc   = '0;
          st_nxt.power = pwr_down(st.power, cfg.fault_step);
          emit         = 1'b1;
        end
      end else begin
        st_nxt.ftc = ftc_inc;
        if (ftc_inc >= cfg.fault_period) begin
          st_nxt.ftc   = '0;
          st_nxt.power = pwr_down(st.power, cfg.fault_step);
          emit         = 1'b1;
        end
      end
    end else if (!st.fault) begin
      st_nxt.ms = '0;
      if (st.have_ref) begin
        if (st.heating) begin
          if (lhs < lo_s) begin
            st_nxt.power = pwr_up(st.power, cfg.power_step);
          end else if (lhs > hi_s) begin
            st_nxt.power = pwr_down(st.power, cfg.power_step);
          end
        end else begin
          if (lhs > -lo_s) begin
            st_nxt.power = pwr_down(st.power, cfg.power_step);
          end else if (lhs < -hi_s) begin
            st_nxt.power = pwr_up(st.power, cfg.power_step);
          end
        end
      end
      st_nxt.have_ref  = 1'b1;
      st_nxt.last_temp = temperature;
      if (st.heating) begin
        if (temperature >= upper_s) st_nxt.heating = 1'b0;
      end else begin
        if (temperature <= lower_s) st_nxt.heating = 1'b1;
      end
      emit = 1'b1;
    end
  end

endmodule

[src/thermal_ramp_rate_cycler_core.sv]
// ----------------------------------------------------------------------------
// thermal_ramp_rate_cycler_core
// Heater power controller that holds a temperature ramp rate between limits
// and cycles between an upper and a lower turn temperature.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transfer per item; opcode 0 is a millisecond tick, opcode 1
//            a temperature sample in 1/16 degree.
//   out_*  : power, display byte, phase and fault flag. Every sample outside
//            fault gives a result; a tick gives one only when the fault
//            latches or a fault period lowers the power.
//   cfg_*  : register writes by index, always ready; write only while idle.
// Timing:
//   An item waits in the input register, is processed by the combinational
//   step logic and lands in the output register that drives out_valid.
//   One item per cycle is accepted while the output is not stalled; the rate
//   is set by the step logic (two 16x16 products, one scaled rise, compares).
// Reset: power 0, heating phase, no reference, fault clear, registers at
//   their defaults.
// Stall: while out_ready is low the output holds, one more item may wait in
//   the input register, then in_ready drops.
// ----------------------------------------------------------------------------
module thermal_ramp_rate_cycler_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic signed [trrc_pkg::TEMP_W-1:0] in_temperature,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [trrc_pkg::POWER_W-1:0]       out_power,
  output logic [trrc_pkg::DISP_W-1:0]        out_display_byte,
  output logic                               out_heating,
  output logic                               out_fault,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [trrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import trrc_pkg::*;

  cfg_t   cfg;
  state_t st_r, st_nxt;
  logic   emit;

  logic                     in_full_r, in_full_nxt;
  logic                     in_op_r;
  logic signed [TEMP_W-1:0] in_temp_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [POWER_W-1:0]       out_power_r;
  logic [DISP_W-1:0]        out_disp_r;
  logic                     out_heating_r, out_fault_r;

  logic out_free, proc_go, in_xfer;

  assign cfg_ready = 1'b1;

  trrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  trrc_step u_step (
    .cfg         (cfg),
    .st          (st_r),
    .opcode      (in_op_r),
    .temperature (in_temp_r),
    .st_nxt      (st_nxt),
    .emit        (emit)
  );

  assign out_free = !out_valid_r || out_ready;
  assign proc_go  = in_full_r && out_free;
  assign in_ready = !in_full_r || proc_go;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_xfer) begin
      in_full_nxt = 1'b1;
    end else if (proc_go) begin
      in_full_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (proc_go) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r        <= 1'b0;
      out_valid_r      <= 1'b0;
      st_r.power       <= '0;
      st_r.heating     <= 1'b1;
      st_r.have_ref    <= 1'b0;
      st_r.last_temp   <= '0;
      st_r.ms          <= '0;
      st_r.fault       <= 1'b0;
      st_r.ftc         <= '0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc_go) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_op_r   <= in_opcode;
      in_temp_r <= in_temperature;
    end
    if (proc_go && emit) begin
      out_power_r   <= st_nxt.power;
      out_disp_r    <= disp_byte(st_nxt.power);
      out_heating_r <= st_nxt.heating;
      out_fault_r   <= st_nxt.fault;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power        = out_power_r;
  assign out_display_byte = out_disp_r;
  assign out_heating      = out_heating_r;
  assign out_fault        = out_fault_r;

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fault |=> st_r.fault)
    else $error("fault flag cleared without reset");

  a_fault_power_falls: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fault |=> st_r.power <= $past(st_r.power))
    else $error("power rose while in fault");

  a_sample_clears_ms: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && in_op_r == OP_SAMPLE && !st_r.fault |=> st_r.ms == '0)
    else $error("sample did not clear elapsed time");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are blocked");

endmodule

[dv/thermal_ramp_rate_cycler_core_tb.sv]
// ----------------------------------------------------------------------------
// thermal_ramp_rate_cycler_core_tb
// Self-checking bench for the ramp-rate heater controller. A queue-fed driver
// sends ticks and temperature samples. A predictor of the power
// loop, phase turns and sample timeout builds the expected results. A monitor
// compares every output transfer with them while both sides idle at random.
// The register set goes through defaults, extremes and random settings. The
// run ends in the latched-fault state.
// ----------------------------------------------------------------------------
module thermal_ramp_rate_cycler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trrc_pkg::*;

  localparam int     CLK_HALF     = 10;
  localparam int     RESET_CYCLES = 11;
  localparam int     DRAIN_CYCLES = 4;
  localparam int     CYCLE_LIMIT  = 3000000;
  localparam int     NUM_REGS     = 8;
  localparam int     LONG_STALL   = 100;
  localparam longint RAMP_SCALE   = 62500;

  typedef struct packed {
    logic                     op;
    logic signed [TEMP_W-1:0] temp;
  } ramp_item_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [DISP_W-1:0]  disp;
    logic               heating;
    logic               fault;
  } heater_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_opcode;
  logic signed [TEMP_W-1:0]    in_temperature;
  logic                        out_valid;
  logic                        out_ready;
  logic [POWER_W-1:0]          out_power;
  logic [DISP_W-1:0]           out_display_byte;
  logic                        out_heating;
  logic                        out_fault;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  thermal_ramp_rate_cycler_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_temperature   (in_temperature),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power        (out_power),
    .out_display_byte (out_display_byte),
    .out_heating      (out_heating),
    .out_fault        (out_fault),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predictor state
  cfg_t               model_cfg = '{upper_turn: RST_UPPER_TURN, lower_turn: RST_LOWER_TURN,
                                    rate_low: RST_RATE_LOW, rate_high: RST_RATE_HIGH,
                                    power_step: RST_POWER_STEP, fault_step: RST_FAULT_STEP,
                                    timeout: RST_TIMEOUT, fault_period: RST_FAULT_PERIOD};
  logic [POWER_W-1:0]       power_lvl   = '0;
  logic                     heat_ph     = 1'b1;
  logic                     have_ref    = 1'b0;
  logic signed [TEMP_W-1:0] prev_temp   = '0;
  logic [MS_W-1:0]          ms_count    = '0;
  logic                     fault_on    = 1'b0;
  logic [FTC_W-1:0]         fault_ticks = '0;

  ramp_item_t     pending_items[$];
  heater_result_t expected_results[$];
  ramp_item_t     next_item;
  heater_result_t exp_r;

  int   fail_count     = 0;
  int   cycle_count    = 0;
  int   taken_count    = 0;
  int   queued_count   = 0;
  int   in_gap_pct     = 0;
  int   out_gap_pct    = 0;
  int   in_gap_left    = 0;
  int   out_gap_left   = 0;
  int   stall_at_count = 32'h7fffffff;
  int   stall_left     = 0;
  logic stall_done     = 1'b0;
  logic in_took        = 1'b0;

  // stimulus shaping
  int   gen_temp   = 0;
  int   gen_ticks  = 0;
  logic gen_rising = 1'b1;

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [POWER_W-1:0] raise_power(input logic [POWER_W-1:0] p,
                                                     input logic [15:0] amt);
    int unsigned sum;
    sum = p + amt;
    return (sum > 65535) ? 16'hFFFF : 16'(sum);
  endfunction

  function automatic logic [POWER_W-1:0] drop_power(input logic [POWER_W-1:0] p,
                                                    input logic [15:0] amt);
    return (amt >= p) ? '0 : p - amt;
  endfunction

  task automatic log_result();
    heater_result_t r;
    r.power   = power_lvl;
    r.disp    = 8'((32'(power_lvl) * 32'd255) / 32'd65535);
    r.heating = heat_ph;
    r.fault   = fault_on;
    expected_results.push_back(r);
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_UPPER_TURN:   model_cfg.upper_turn   = data[TURN_W-1:0];
      REG_LOWER_TURN:   model_cfg.lower_turn   = data[TURN_W-1:0];
      REG_RATE_LOW:     model_cfg.rate_low     = data;
      REG_RATE_HIGH:    model_cfg.rate_high    = data;
      REG_POWER_STEP:   model_cfg.power_step   = data;
      REG_FAULT_STEP:   model_cfg.fault_step   = data;
      REG_TIMEOUT:      model_cfg.timeout      = data;
      REG_FAULT_PERIOD: model_cfg.fault_period = data[FTC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic advance_heater(input logic op, input logic signed [TEMP_W-1:0] temp);
    longint rise;
    longint lo_lim;
    longint hi_lim;
    if (op == OP_TICK) begin
      if (ms_count != '1) ms_count++;
      if (!fault_on) begin
        if (ms_count > model_cfg.timeout) begin
          fault_on    = 1'b1;
          fault_ticks = '0;
          power_lvl   = drop_power(power_lvl, model_cfg.fault_step);
          log_result();
        end
      end else begin
        fault_ticks++;
        if (fault_ticks >= model_cfg.fault_period) begin
          fault_ticks = '0;
          power_lvl   = drop_power(power_lvl, model_cfg.fault_step);
          log_result();
        end
      end
    end else if (!fault_on) begin
      if (have_ref) begin
        rise   = longint'(int'(temp) - int'(prev_temp)) * RAMP_SCALE;
        lo_lim = longint'(model_cfg.rate_low) * longint'(ms_count);
        hi_lim = longint'(model_cfg.rate_high) * longint'(ms_count);
        if (heat_ph) begin
          if (rise < lo_lim) power_lvl = raise_power(power_lvl, model_cfg.power_step);
          else if (rise > hi_lim) power_lvl = drop_power(power_lvl, model_cfg.power_step);
        end else begin
          if (rise > -lo_lim) power_lvl = drop_power(power_lvl, model_cfg.power_step);
          else if (rise < -hi_lim) power_lvl = raise_power(power_lvl, model_cfg.power_step);
        end
      end
      ms_count  = '0;
      have_ref  = 1'b1;
      prev_temp = temp;
      if (heat_ph) begin
        if (int'(temp) >= int'(model_cfg.upper_turn)) heat_ph = 1'b0;
      end else begin
        if (int'(temp) <= int'(model_cfg.lower_turn)) heat_ph = 1'b1;
      end
      log_result();
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap_left > 0) begin
        in_valid    <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(1, 100) <= in_gap_pct) begin
        in_valid    <= 1'b0;
        in_gap_left <= $urandom_range(0, 2);
      end else begin
        next_item      = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_opcode      <= next_item.op;
        in_temperature <= next_item.temp;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && taken_count >= stall_at_count) begin
      out_ready  <= 1'b0;
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
    end else if (out_gap_left > 0) begin
      out_ready    <= 1'b0;
      out_gap_left <= out_gap_left - 1;
    end else if ($urandom_range(1, 100) <= out_gap_pct) begin
      out_ready    <= 1'b0;
      out_gap_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        advance_heater(in_opcode, in_temperature);
        taken_count <= taken_count + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result power=%0d display=%0d heating=%0b fault=%0b",
                   $time, out_power, out_display_byte, out_heating, out_fault);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_power !== exp_r.power) begin
            $display("%0t: power expected %0d actual %0d", $time, exp_r.power, out_power);
            fail_count++;
          end
          if (out_display_byte !== exp_r.disp) begin
            $display("%0t: display_byte expected %0d actual %0d",
                     $time, exp_r.disp, out_display_byte);
            fail_count++;
          end
          if (out_heating !== exp_r.heating) begin
            $display("%0t: heating expected %0b actual %0b", $time, exp_r.heating, out_heating);
            fail_count++;
          end
          if (out_fault !== exp_r.fault) begin
            $display("%0t: fault expected %0b actual %0b", $time, exp_r.fault, out_fault);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_tick();
    pending_items.push_back('{op: OP_TICK, temp: 16'($urandom)});
    gen_ticks++;
    queued_count++;
  endtask

  task automatic push_sample(input int t);
    pending_items.push_back('{op: OP_SAMPLE, temp: 16'(t)});
    gen_ticks = 0;
    queued_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_UPPER_TURN, {1'($urandom), c.upper_turn});
    write_reg(REG_LOWER_TURN, {1'($urandom), c.lower_turn});
    write_reg(REG_RATE_LOW, c.rate_low);
    write_reg(REG_RATE_HIGH, c.rate_high);
    write_reg(REG_POWER_STEP, c.power_step);
    write_reg(REG_FAULT_STEP, c.fault_step);
    write_reg(REG_TIMEOUT, c.timeout);
    write_reg(REG_FAULT_PERIOD, {6'($urandom), c.fault_period});
    // unused index, must have no effect
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.lower_turn   = 15'($urandom_range(0, 30000));
    c.upper_turn   = c.lower_turn + 15'($urandom_range(0, 400));
    c.rate_low     = 16'($urandom_range(200, 30000));
    c.rate_high    = c.rate_low + 16'($urandom_range(0, 30000));
    c.power_step   = 16'($urandom_range(0, 4000));
    c.fault_step   = 16'($urandom);
    c.timeout      = 16'($urandom_range(150, 60000));
    c.fault_period = 10'($urandom_range(1, 1023));
    return c;
  endfunction

  // tick gaps then a sample near the configured ramp rate, plus noise
  task automatic gen_ramp(input int n_items, input int noise_pct);
    int stop_at;
    int gap;
    int rate;
    int delta;
    stop_at = queued_count + n_items;
    while (queued_count < stop_at) begin
      if ($urandom_range(1, 100) <= noise_pct) begin
        if ($urandom_range(0, 1) == 1 && gen_ticks < int'(model_cfg.timeout)) push_tick();
        else push_sample(int'($urandom_range(0, 36863)) - 4096);
      end else begin
        gap = int'(model_cfg.timeout) - gen_ticks;
        if (gap > 150) gap = 150;
        gap = $urandom_range(0, gap);
        repeat (gap) push_tick();
        if ($urandom_range(1, 20) == 1) begin
          gen_temp = int'(model_cfg.lower_turn) + int'($urandom_range(0, 400)) - 100;
        end else begin
          rate  = $urandom_range(model_cfg.rate_low, model_cfg.rate_high);
          rate  = rate * int'($urandom_range(70, 130)) / 100;
          delta = (rate * gen_ticks + 31250) / 62500 + int'($urandom_range(0, 2)) - 1;
          gen_temp += gen_rising ? delta : -delta;
        end
        if (gen_temp > 32767) gen_temp = 32767;
        if (gen_temp < -4096) gen_temp = -4096;
        push_sample(gen_temp);
        if (gen_temp >= int'(model_cfg.upper_turn)) gen_rising = 1'b0;
        else if (gen_temp <= int'(model_cfg.lower_turn)) gen_rising = 1'b1;
      end
    end
    push_sample(gen_temp);
  endtask

  task automatic gen_fault_mix(input int n_items);
    repeat (n_items) begin
      if ($urandom_range(1, 100) <= 85) push_tick();
      else push_sample(int'($urandom_range(0, 36863)) - 4096);
    end
  endtask

  initial begin
    cfg_t c;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_TICK;
    in_temperature = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_UPPER_TURN;
    cfg_data       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings
    in_gap_pct  = 15;
    out_gap_pct = 15;
    repeat (3) push_tick();
    push_sample(-4096);
    repeat (4) push_tick();
    push_sample(-4000);
    push_sample(-4000);
    push_sample(-3990);
    push_sample(-4000);
    repeat (2) push_tick();
    push_sample(-4000);
    push_sample(32767);
    repeat (3) push_tick();
    push_sample(32767);
    push_sample(0);
    push_sample(4800);
    gen_temp = 4800;
    settle();

    // extremes: full-scale power step and rates, crossed turn points flip the phase
    in_gap_pct   = 20;
    out_gap_pct  = 20;
    c.upper_turn   = '0;
    c.lower_turn   = '1;
    c.rate_low     = '1;
    c.rate_high    = '1;
    c.power_step   = '1;
    c.fault_step   = '0;
    c.timeout      = '1;
    c.fault_period = '0;
    program_regs(c);
    gen_ramp(150, 30);
    settle();

    // extremes: zero rates, unit power step, timeout of one tick
    in_gap_pct   = 0;
    out_gap_pct  = 0;
    c.upper_turn   = '1;
    c.lower_turn   = '0;
    c.rate_low     = '0;
    c.rate_high    = '0;
    c.power_step   = 16'd1;
    c.fault_step   = '1;
    c.timeout      = 16'd1;
    c.fault_period = '1;
    program_regs(c);
    gen_ramp(150, 30);
    settle();

    // random settings
    in_gap_pct  = 15;
    out_gap_pct = 25;
    program_regs(random_cfg());
    gen_temp = int'(model_cfg.lower_turn);
    gen_ramp(150, 10);
    settle();

    // long receiver stall with the sender still busy
    in_gap_pct  = 10;
    out_gap_pct = 10;
    c = random_cfg();
    c.timeout = 16'd12;
    program_regs(c);
    stall_at_count = taken_count + 50;
    gen_ramp(150, 10);
    settle();

    in_gap_pct  = 30;
    out_gap_pct = 0;
    program_regs(random_cfg());
    gen_ramp(150, 15);
    settle();

    in_gap_pct  = 0;
    out_gap_pct = 30;
    program_regs(random_cfg());
    gen_ramp(150, 10);
    settle();

    // largest timeout never latches the fault
    in_gap_pct  = 5;
    out_gap_pct = 5;
    c = random_cfg();
    c.timeout = '1;
    program_regs(c);
    repeat (200) push_tick();
    push_sample(gen_temp);
    settle();

    // timeout latches the fault; power drops every fault period
    in_gap_pct  = 20;
    out_gap_pct = 20;
    c = random_cfg();
    c.timeout      = 16'($urandom_range(5, 30));
    c.fault_period = 10'($urandom_range(2, 6));
    c.fault_step   = 16'($urandom_range(100, 3000));
    program_regs(c);
    repeat (int'(c.timeout) + 1) push_tick();
    gen_fault_mix(200);
    settle();

    in_gap_pct  = 10;
    out_gap_pct = 30;
    c = random_cfg();
    c.fault_period = '0;
    c.fault_step   = 16'($urandom_range(1, 200));
    program_regs(c);
    gen_fault_mix(150);
    settle();

    in_gap_pct  = 0;
    out_gap_pct = 0;
    c = random_cfg();
    c.fault_period = '1;
    program_regs(c);
    gen_fault_mix(250);
    settle();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
